/* hw/rtl/byte_ring_fifo_with_peek_assert.svh */
// Assertion macros for the byte ring queue.
`ifndef BYTE_RING_FIFO_WITH_PEEK_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_PEEK_ASSERT_SVH

// Same-cycle property.
`define BRFQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication.
`define BRFQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/brfq_pkg.sv */
package brfq_pkg;

  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned BURST_W   = $clog2(MAX_BURST + 1);
  localparam int unsigned S_DATA_W  = 32;
  localparam int unsigned S_USER_W  = 3;
  localparam int unsigned M_DATA_W  = 24;
  localparam int unsigned M_USER_W  = 4;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_OVW     = 3'd3,
    ST_OVR     = 3'd4,
    ST_INVALID = 3'd5
  } status_e;

endpackage

/* hw/rtl/brfq_ram.sv */
module brfq_ram #(
  parameter int unsigned WIDTH = brfq_pkg::BYTE_W,
  parameter int unsigned DEPTH = brfq_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/byte_ring_fifo_with_peek.sv */
// Byte ring queue with peek.
// Input stream (s_axis): one transfer per command (push byte, pop, peek, clear).
// Output stream (m_axis): one result transfer per push, clear or rejected
// command; n transfers for a valid pop or peek of n bytes, tlast on the final.
// cfg_we_i/cfg_wdata_i write the capacity (clamped to 1..min(DEPTH, 511)) and empty the
// queue; write only while the block is idle.
// Timing: push, clear and rejected results enter the output register at the
// accepting edge. A pop or peek of n bytes reads each stored byte once via
// the memory's single read port (peek bytes past the fill level go out as
// zero unread) through the read register, then the output register, one
// byte per cycle unless the receiver stalls; no command is taken meanwhile.
// Reset: capacity min(256, DEPTH), queue empty, no push request open; the
// byte memory is not cleared.
// A stalled receiver holds the output register; a burst waits with at most
// one byte parked in the memory read register, and no new command is taken
// until the output register is free.
module byte_ring_fifo_with_peek #(
  parameter int unsigned DEPTH = brfq_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brfq_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // data_in[7:0], request_len[16:8], peek_index[24:17], zero pad
  input  logic [brfq_pkg::S_DATA_W-1:0] s_axis_tdata,
  // operation[1:0], first_of_request[2]
  input  logic [brfq_pkg::S_USER_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // data_out[7:0], fill_level[16:8], zero pad
  output logic [brfq_pkg::M_DATA_W-1:0] m_axis_tdata,
  // data_valid[0], status[3:1]
  output logic [brfq_pkg::M_USER_W-1:0] m_axis_tuser,
  output logic                          m_axis_tlast
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = brfq_pkg::CNT_W;
  localparam int unsigned BW = brfq_pkg::BURST_W;
  localparam logic [CW-1:0] CAP_RST = CW'(DEPTH < 256 ? DEPTH : 256);
  localparam logic [CW-1:0] CAP_MAX = CW'(DEPTH < 511 ? DEPTH : 511);
  localparam logic [CW-1:0] BURST_MAX = CW'(brfq_pkg::MAX_BURST);

  typedef enum logic {
    S_IDLE,
    S_BURST
  } state_e;

  function automatic logic [CW-1:0] wrap(input logic [CW:0] s, input logic [CW-1:0] c);
    logic [CW:0] r;
    r = (s >= {1'b0, c}) ? (s - {1'b0, c}) : s;
    return r[CW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [CW-1:0] cap_q, cap_d;
  logic [CW-1:0] rp_q, rp_d;
  logic [CW-1:0] wp_q, wp_d;
  logic [CW-1:0] fc_q, fc_d;
  logic [CW-1:0] left_q, left_d;
  logic          drop_q, drop_d;
  logic [CW-1:0] addr_q, addr_d;
  logic [CW-1:0] off_q, off_d;
  logic [BW-1:0] bleft_q, bleft_d;
  logic          bpop_q, bpop_d;
  brfq_pkg::status_e bst_q, bst_d;
  logic          pend_q, pend_d;
  logic          phold_q, phold_d;
  logic          plast_q, plast_d;
  logic          ov_q, ov_d;
  logic [brfq_pkg::BYTE_W-1:0] od_q, od_d;
  logic          odv_q, odv_d;
  logic          olast_q, olast_d;
  brfq_pkg::status_e ost_q, ost_d;
  logic [CW-1:0] ofill_q, ofill_d;

  brfq_pkg::op_e op;
  logic          first;
  logic [brfq_pkg::BYTE_W-1:0] din;
  logic [CW-1:0] len;
  logic [brfq_pkg::IDX_W-1:0] pidx;
  logic          accept, mv, iss, held, store, full;
  logic [CW-1:0] free;
  logic          ram_we, ram_re;
  logic [brfq_pkg::BYTE_W-1:0] ram_rdata;

  assign op     = brfq_pkg::op_e'(s_axis_tuser[1:0]);
  assign first  = s_axis_tuser[2];
  assign din    = s_axis_tdata[7:0];
  assign len    = s_axis_tdata[16:8];
  assign pidx   = s_axis_tdata[24:17];

  assign s_axis_tready = (state_q == S_IDLE) && (!ov_q || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign full   = fc_q >= cap_q;
  assign free   = cap_q - fc_q;
  assign mv     = pend_q && (!ov_q || m_axis_tready);
  assign iss    = (state_q == S_BURST) && (bleft_q != '0) && (!pend_q || mv);
  assign held   = bpop_q || (off_q < fc_q);
  assign ram_re = iss && held;

  always_comb begin
    state_d = state_q;
    cap_d   = cap_q;
    rp_d    = rp_q;
    wp_d    = wp_q;
    fc_d    = fc_q;
    left_d  = left_q;
    drop_d  = drop_q;
    addr_d  = addr_q;
    off_d   = off_q;
    bleft_d = bleft_q;
    bpop_d  = bpop_q;
    bst_d   = bst_q;
    pend_d  = pend_q;
    phold_d = phold_q;
    plast_d = plast_q;
    ov_d    = ov_q && !m_axis_tready;
    od_d    = od_q;
    odv_d   = odv_q;
    olast_d = olast_q;
    ost_d   = ost_q;
    ofill_d = ofill_q;
    store   = 1'b0;
    ram_we  = 1'b0;

    if (accept) begin
      ov_d    = 1'b1;
      od_d    = '0;
      odv_d   = 1'b0;
      olast_d = 1'b1;
      ost_d   = brfq_pkg::ST_OK;
      ofill_d = fc_q;
      unique case (op)
        brfq_pkg::OP_PUSH: begin
          if (first) begin
            left_d = '0;
            drop_d = 1'b0;
            if (len == '0) begin
              ost_d = brfq_pkg::ST_INVALID;
            end else if (full) begin
              drop_d = 1'b1;
              left_d = len - 1'b1;
              ost_d  = brfq_pkg::ST_FULL;
            end else if (len > free) begin
              drop_d = 1'b1;
              left_d = len - 1'b1;
              ost_d  = brfq_pkg::ST_OVW;
            end else begin
              left_d = len - 1'b1;
              store  = 1'b1;
            end
          end else if (left_q == '0) begin
            ost_d = brfq_pkg::ST_INVALID;
          end else begin
            left_d = left_q - 1'b1;
            if (drop_q) begin
              if (left_q == CW'(1)) begin
                drop_d = 1'b0;
              end
              ost_d = full ? brfq_pkg::ST_FULL : brfq_pkg::ST_OVW;
            end else if (full) begin
              ost_d = brfq_pkg::ST_FULL;
            end else begin
              store = 1'b1;
            end
          end
          if (store) begin
            ram_we  = 1'b1;
            wp_d    = wrap({1'b0, wp_q} + 1'b1, cap_q);
            fc_d    = fc_q + 1'b1;
            ost_d   = (fc_d >= cap_q) ? brfq_pkg::ST_FULL : brfq_pkg::ST_OK;
          end
          ofill_d = fc_d;
        end
        brfq_pkg::OP_CLEAR: begin
          rp_d    = '0;
          wp_d    = '0;
          fc_d    = '0;
          left_d  = '0;
          drop_d  = 1'b0;
          ofill_d = '0;
        end
        default: begin
          if (len == '0 || len > BURST_MAX) begin
            ost_d = brfq_pkg::ST_INVALID;
          end else if (op == brfq_pkg::OP_POP) begin
            if (fc_q == '0) begin
              ost_d = brfq_pkg::ST_EMPTY;
            end else if (len > fc_q) begin
              ost_d = brfq_pkg::ST_OVR;
            end else begin
              ov_d    = ov_q && !m_axis_tready;
              state_d = S_BURST;
              addr_d  = rp_q;
              rp_d    = wrap({1'b0, rp_q} + {1'b0, len}, cap_q);
              fc_d    = fc_q - len;
              bst_d   = (fc_q == len) ? brfq_pkg::ST_EMPTY : brfq_pkg::ST_OK;
              bleft_d = len[BW-1:0];
              bpop_d  = 1'b1;
            end
          end else if ({1'b0, pidx} >= cap_q) begin
            ost_d = brfq_pkg::ST_INVALID;
          end else begin
            ov_d    = ov_q && !m_axis_tready;
            state_d = S_BURST;
            addr_d  = wrap({1'b0, rp_q} + {2'b0, pidx}, cap_q);
            off_d   = {1'b0, pidx};
            bst_d   = brfq_pkg::ST_OK;
            bleft_d = len[BW-1:0];
            bpop_d  = 1'b0;
          end
        end
      endcase
    end

    if (iss) begin
      pend_d  = 1'b1;
      phold_d = held;
      plast_d = (bleft_q == BW'(1));
      bleft_d = bleft_q - 1'b1;
      addr_d  = wrap({1'b0, addr_q} + 1'b1, cap_q);
      off_d   = off_q + 1'b1;
    end else if (mv) begin
      pend_d = 1'b0;
    end

    if (mv) begin
      ov_d    = 1'b1;
      od_d    = phold_q ? ram_rdata : '0;
      odv_d   = 1'b1;
      olast_d = plast_q;
      ost_d   = bst_q;
      ofill_d = fc_q;
      if (plast_q) begin
        state_d = S_IDLE;
      end
    end

    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        cap_d = CW'(1);
      end else if (cfg_wdata_i > CAP_MAX) begin
        cap_d = CAP_MAX;
      end else begin
        cap_d = cfg_wdata_i;
      end
      rp_d   = '0;
      wp_d   = '0;
      fc_d   = '0;
      left_d = '0;
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= CAP_RST;
      rp_q    <= '0;
      wp_q    <= '0;
      fc_q    <= '0;
      left_q  <= '0;
      drop_q  <= 1'b0;
      addr_q  <= '0;
      off_q   <= '0;
      bleft_q <= '0;
      bpop_q  <= 1'b0;
      bst_q   <= brfq_pkg::ST_OK;
      pend_q  <= 1'b0;
      phold_q <= 1'b0;
      plast_q <= 1'b0;
      ov_q    <= 1'b0;
      od_q    <= '0;
      odv_q   <= 1'b0;
      olast_q <= 1'b0;
      ost_q   <= brfq_pkg::ST_OK;
      ofill_q <= '0;
    end else begin
      state_q <= state_d;
      cap_q   <= cap_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      fc_q    <= fc_d;
      left_q  <= left_d;
      drop_q  <= drop_d;
      addr_q  <= addr_d;
      off_q   <= off_d;
      bleft_q <= bleft_d;
      bpop_q  <= bpop_d;
      bst_q   <= bst_d;
      pend_q  <= pend_d;
      phold_q <= phold_d;
      plast_q <= plast_d;
      ov_q    <= ov_d;
      od_q    <= od_d;
      odv_q   <= odv_d;
      olast_q <= olast_d;
      ost_q   <= ost_d;
      ofill_q <= ofill_d;
    end
  end

  brfq_ram #(
    .WIDTH(brfq_pkg::BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(wp_q)),
    .wdata_i(din),
    .re_i   (ram_re),
    .raddr_i(AW'(addr_q)),
    .rdata_o(ram_rdata)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'b0, ofill_q, od_q};
  assign m_axis_tuser  = {ost_q, odv_q};
  assign m_axis_tlast  = olast_q;

endmodule

/* hw/rtl/brfq_chk.sv */
`include "byte_ring_fifo_with_peek_assert.svh"

module brfq_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [brfq_pkg::CNT_W-1:0]    cfg_wdata_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [brfq_pkg::S_DATA_W-1:0] s_axis_tdata,
  input logic [brfq_pkg::S_USER_W-1:0] s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [brfq_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic [brfq_pkg::M_USER_W-1:0] m_axis_tuser,
  input logic                          m_axis_tlast
);

  `BRFQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output transfer changed")
  `BRFQ_ASSERT(a_nodata_zero, clk_i, rst_ni, !(m_axis_tvalid && !m_axis_tuser[0]) || (m_axis_tdata[7:0] == 8'd0), "data_out nonzero without data_valid")
  `BRFQ_ASSERT(a_status_code, clk_i, rst_ni, !m_axis_tvalid || m_axis_tuser[3:1] == brfq_pkg::ST_OK || m_axis_tuser[3:1] == brfq_pkg::ST_EMPTY || m_axis_tuser[3:1] == brfq_pkg::ST_FULL || m_axis_tuser[3:1] == brfq_pkg::ST_OVW || m_axis_tuser[3:1] == brfq_pkg::ST_OVR || m_axis_tuser[3:1] == brfq_pkg::ST_INVALID, "undefined status code")
  `BRFQ_ASSERT(a_empty_fill, clk_i, rst_ni, !(m_axis_tvalid && m_axis_tuser[3:1] == brfq_pkg::ST_EMPTY) || (m_axis_tdata[16:8] == 9'd0), "empty status with nonzero fill level")

endmodule

bind byte_ring_fifo_with_peek brfq_chk u_brfq_chk (.*);
